// ===== rtl/core/apsp_pkg.sv =====
// Shared types, constants, microcode and helpers of the all-pairs shortest path block.
package apsp_pkg;

   localparam int VERTICES      = 16;
   localparam int WEIGHT_BITS   = 16;
   localparam int IDX_BITS      = (VERTICES > 1) ? $clog2(VERTICES) : 1;
   localparam int ENTRIES       = VERTICES * VERTICES;
   localparam int ADDR_BITS     = $clog2(ENTRIES);
   localparam int DIST_BITS     = WEIGHT_BITS + IDX_BITS;
   localparam int FIELD_W_BITS  = 16;
   localparam int LOAD_BITS     = (WEIGHT_BITS < FIELD_W_BITS) ? WEIGHT_BITS : FIELD_W_BITS;
   localparam int OUT_DIST_BITS = 20;
   localparam int STEP_BITS     = 4;

   localparam logic [IDX_BITS-1:0] V_LAST       = IDX_BITS'(VERTICES - 1);
   localparam logic [63:0]         OUT_DIST_MAX = 64'((64'd1 << OUT_DIST_BITS) - 64'd1);

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_RUN  = 2'd1,
      OP_READ = 2'd2
   } op_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [3:0]  row;
      logic [3:0]  col;
      logic [15:0] weight;
      logic        weight_infinite;
   } req_item_type;

   typedef struct packed {
      logic [1:0]               op_echo;
      logic [OUT_DIST_BITS-1:0] distance;
      logic                     distance_infinite;
      logic [3:0]               predecessor;
   } rsp_item_type;

   typedef struct packed {
      logic                 inf;
      logic [DIST_BITS-1:0] value;
   } dist_word_type;

   localparam dist_word_type INFINITY = '{inf: 1'b1, value: '0};

   typedef enum logic [STEP_BITS-1:0] {
      S_WAIT       = 4'd0,
      S_LOAD       = 4'd1,
      S_READ_ISSUE = 4'd2,
      S_READ_DONE  = 4'd3,
      S_RUN_INIT   = 4'd4,
      S_ROW_ISSUE  = 4'd5,
      S_ROW_LATCH  = 4'd6,
      S_SWEEP      = 4'd7,
      S_DRAIN      = 4'd8,
      S_RUN_DONE   = 4'd9
   } step_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_LOAD,
      ACT_RUN_INIT,
      ACT_ROW_ISSUE,
      ACT_ROW_LATCH,
      ACT_SWEEP,
      ACT_DRAIN
   } action_type;

   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_ZERO,
      EMIT_READ
   } emit_type;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_DISPATCH,
      COND_SWEEP_MORE,
      COND_ROUND_MORE
   } cond_type;

   typedef struct packed {
      logic       req_ready;
      action_type act;
      emit_type   emit;
      cond_type   cond;
      step_type   target;
   } ctl_word_type;

   function automatic ctl_word_type ucode(input step_type s);
      ctl_word_type c;
      c = '{req_ready: 1'b0, act: ACT_NONE, emit: EMIT_NONE, cond: COND_ALWAYS,
            target: S_WAIT};
      unique case (s)
         S_WAIT:       begin
            c.req_ready = 1'b1;
            c.cond      = COND_DISPATCH;
         end
         S_LOAD:       begin
            c.act  = ACT_LOAD;
            c.emit = EMIT_ZERO;
         end
         S_READ_ISSUE: c.target = S_READ_DONE;
         S_READ_DONE:  c.emit = EMIT_READ;
         S_RUN_INIT:   begin
            c.act    = ACT_RUN_INIT;
            c.target = S_ROW_ISSUE;
         end
         S_ROW_ISSUE:  begin
            c.act    = ACT_ROW_ISSUE;
            c.target = S_ROW_LATCH;
         end
         S_ROW_LATCH:  begin
            c.act    = ACT_ROW_LATCH;
            c.target = S_SWEEP;
         end
         S_SWEEP:      begin
            c.act    = ACT_SWEEP;
            c.cond   = COND_SWEEP_MORE;
            c.target = S_SWEEP;
         end
         S_DRAIN:      begin
            c.act    = ACT_DRAIN;
            c.cond   = COND_ROUND_MORE;
            c.target = S_ROW_ISSUE;
         end
         S_RUN_DONE:   c.emit = EMIT_ZERO;
         default:      c.target = S_WAIT;
      endcase
      return c;
   endfunction

   function automatic logic [ADDR_BITS-1:0] entry_addr(input logic [IDX_BITS-1:0] r,
                                                       input logic [IDX_BITS-1:0] c);
      return ADDR_BITS'(r) * ADDR_BITS'(VERTICES) + ADDR_BITS'(c);
   endfunction

   function automatic logic [OUT_DIST_BITS-1:0] sat_distance(
         input logic [DIST_BITS-1:0] value);
      if (64'(value) > OUT_DIST_MAX) begin
         return '1;
      end
      return OUT_DIST_BITS'(value);
   endfunction

endpackage

// ===== rtl/core/all_pairs_shortest_path.sv =====
// Top level: microcoded Floyd-Warshall engine with distance and predecessor memories.
// A load (and operation code 3) passes the load step, a read the issue and done steps, and a run
// the init step, then per row the issue, latch, sweep and drain steps, then the done step.
// One item at a time: the next is taken the cycle after its result is produced; the sweep over
// a row does one relaxation per cycle. Synchronous reset clears the sequencer and result slot.
module all_pairs_shortest_path (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  apsp_pkg::req_item_type req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output apsp_pkg::rsp_item_type rsp_payload
);

   apsp_pkg::step_type      step_ff, step_in;
   apsp_pkg::ctl_word_type  ctl;
   apsp_pkg::req_item_type  req_ff, req_in;
   apsp_pkg::rsp_item_type  rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [apsp_pkg::IDX_BITS-1:0] w_ff, w_in, u_ff, u_in, v_ff, v_in, pv_v_ff, pv_v_in;
   logic                    pv_valid_ff, pv_valid_in;
   apsp_pkg::dist_word_type duw_ff, duw_in;

   logic                    stall, emit_fire, req_fire, in_range, load_we, relax_we;
   logic [apsp_pkg::IDX_BITS-1:0]  row_idx, col_idx;
   logic [apsp_pkg::ADDR_BITS-1:0] addr_req, rd_a_addr, rd_b_addr, wr_addr;
   apsp_pkg::dist_word_type dist_a_rd, dist_b_rd, wr_dist;
   logic [apsp_pkg::IDX_BITS-1:0]  pred_rd, wr_pred;
   logic [apsp_pkg::DIST_BITS:0]   sum;

   assign ctl       = apsp_pkg::ucode(step_ff);
   assign stall     = (ctl.emit != apsp_pkg::EMIT_NONE) && rsp_valid_ff && !rsp_ready;
   assign emit_fire = (ctl.emit != apsp_pkg::EMIT_NONE) && !stall;
   assign req_ready = ctl.req_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign row_idx  = apsp_pkg::IDX_BITS'(req_ff.row);
   assign col_idx  = apsp_pkg::IDX_BITS'(req_ff.col);
   assign in_range = (req_ff.row < apsp_pkg::VERTICES) && (req_ff.col < apsp_pkg::VERTICES);
   assign addr_req = apsp_pkg::entry_addr(row_idx, col_idx);

   // Next step of the sequencer.
   always_comb begin
      step_in = step_ff;
      if (!stall) begin
         unique case (ctl.cond)
            apsp_pkg::COND_NEXT:       step_in = apsp_pkg::step_type'(step_ff + 1'b1);
            apsp_pkg::COND_ALWAYS:     step_in = ctl.target;
            apsp_pkg::COND_DISPATCH: begin
               if (req_valid) begin
                  unique case (req_payload.operation)
                     apsp_pkg::OP_RUN:  step_in = apsp_pkg::S_RUN_INIT;
                     apsp_pkg::OP_READ: step_in = apsp_pkg::S_READ_ISSUE;
                     default:           step_in = apsp_pkg::S_LOAD;
                  endcase
               end
            end
            apsp_pkg::COND_SWEEP_MORE: begin
               step_in = (v_ff != apsp_pkg::V_LAST) ? ctl.target
                                                    : apsp_pkg::step_type'(step_ff + 1'b1);
            end
            apsp_pkg::COND_ROUND_MORE: begin
               step_in = (u_ff == apsp_pkg::V_LAST && w_ff == apsp_pkg::V_LAST)
                         ? apsp_pkg::step_type'(step_ff + 1'b1) : ctl.target;
            end
            default:                   step_in = apsp_pkg::S_WAIT;
         endcase
      end
   end

   // Datapath driven by the control word.
   always_comb begin
      req_in      = req_fire ? req_payload : req_ff;
      w_in        = w_ff;
      u_in        = u_ff;
      v_in        = v_ff;
      pv_v_in     = pv_v_ff;
      pv_valid_in = 1'b0;
      duw_in      = duw_ff;
      rd_a_addr   = addr_req;
      unique case (ctl.act)
         apsp_pkg::ACT_RUN_INIT: begin
            w_in = '0;
            u_in = '0;
         end
         apsp_pkg::ACT_ROW_ISSUE: rd_a_addr = apsp_pkg::entry_addr(u_ff, w_ff);
         apsp_pkg::ACT_ROW_LATCH: begin
            duw_in = dist_a_rd;
            v_in   = '0;
         end
         apsp_pkg::ACT_SWEEP: begin
            rd_a_addr   = apsp_pkg::entry_addr(w_ff, v_ff);
            pv_valid_in = 1'b1;
            pv_v_in     = v_ff;
            v_in        = v_ff + 1'b1;
         end
         apsp_pkg::ACT_DRAIN: begin
            if (u_ff == apsp_pkg::V_LAST) begin
               u_in = '0;
               w_in = w_ff + 1'b1;
            end else begin
               u_in = u_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign rd_b_addr = apsp_pkg::entry_addr(u_ff, v_ff);
   assign sum = {1'b0, duw_ff.value} + {1'b0, dist_a_rd.value};

   assign relax_we = pv_valid_ff && (w_ff != u_ff) && (w_ff != pv_v_ff)
                     && !duw_ff.inf && !dist_a_rd.inf
                     && (dist_b_rd.inf || (sum < {1'b0, dist_b_rd.value}));
   assign load_we  = (ctl.act == apsp_pkg::ACT_LOAD) && !stall
                     && (req_ff.operation == apsp_pkg::OP_LOAD) && in_range;

   always_comb begin
      if (load_we) begin
         wr_addr = addr_req;
         wr_pred = row_idx;
         if (req_ff.weight_infinite) begin
            wr_dist = apsp_pkg::INFINITY;
         end else begin
            wr_dist.inf   = 1'b0;
            wr_dist.value = apsp_pkg::DIST_BITS'(req_ff.weight[apsp_pkg::LOAD_BITS-1:0]);
         end
      end else begin
         wr_addr       = apsp_pkg::entry_addr(u_ff, pv_v_ff);
         wr_pred       = pred_rd;
         wr_dist.inf   = 1'b0;
         wr_dist.value = apsp_pkg::DIST_BITS'(sum);
      end
   end

   // Result slot.
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (emit_fire) begin
         rsp_valid_in              = 1'b1;
         rsp_in.op_echo            = req_ff.operation;
         rsp_in.distance           = '0;
         rsp_in.distance_infinite  = 1'b0;
         rsp_in.predecessor        = '0;
         if (ctl.emit == apsp_pkg::EMIT_READ && in_range) begin
            rsp_in.distance_infinite = dist_a_rd.inf;
            rsp_in.predecessor       = 4'(pred_rd);
            if (!dist_a_rd.inf) begin
               rsp_in.distance = apsp_pkg::sat_distance(dist_a_rd.value);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= apsp_pkg::S_WAIT;
         rsp_valid_ff <= 1'b0;
         pv_valid_ff  <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         pv_valid_ff  <= pv_valid_in;
      end
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
      w_ff    <= w_in;
      u_ff    <= u_in;
      v_ff    <= v_in;
      pv_v_ff <= pv_v_in;
      duw_ff  <= duw_in;
   end

   apsp_ram #(.WIDTH($bits(apsp_pkg::dist_word_type)), .DEPTH(apsp_pkg::ENTRIES)) dist_a_ram (
      .clock   (clock),
      .wr_en   (load_we || relax_we),
      .wr_addr (wr_addr),
      .wr_data (wr_dist),
      .rd_addr (rd_a_addr),
      .rd_data (dist_a_rd)
   );

   apsp_ram #(.WIDTH($bits(apsp_pkg::dist_word_type)), .DEPTH(apsp_pkg::ENTRIES)) dist_b_ram (
      .clock   (clock),
      .wr_en   (load_we || relax_we),
      .wr_addr (wr_addr),
      .wr_data (wr_dist),
      .rd_addr (rd_b_addr),
      .rd_data (dist_b_rd)
   );

   apsp_ram #(.WIDTH(apsp_pkg::IDX_BITS), .DEPTH(apsp_pkg::ENTRIES)) pred_ram (
      .clock   (clock),
      .wr_en   (load_we || relax_we),
      .wr_addr (wr_addr),
      .wr_data (wr_pred),
      .rd_addr (rd_a_addr),
      .rd_data (pred_rd)
   );

   a_relax_no_hazard: assert property (@(posedge clock) disable iff (reset)
      (relax_we && step_ff == apsp_pkg::S_SWEEP)
         |-> (wr_addr != rd_a_addr) && (wr_addr != rd_b_addr))
      else $error("relaxation write collides with a read issued in the same cycle");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(emit_fire))
      else $error("result raised without an emitting step");

   a_sweep_flow: assert property (@(posedge clock) disable iff (reset)
      (step_ff == apsp_pkg::S_SWEEP) |=>
         (step_ff == apsp_pkg::S_SWEEP || step_ff == apsp_pkg::S_DRAIN))
      else $error("sweep left by an unexpected step");

   a_accept_leaves_wait: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (step_ff != apsp_pkg::S_WAIT))
      else $error("accepted item was not started");

endmodule

// ===== rtl/core/apsp_ram.sv =====
// Generic single-port-write, single-port-read memory with a registered read.
module apsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
